/* rtl/core/btl_pkg.sv */
// shared types and constants for the bresenham line octant stepper
`default_nettype none

package btl_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DEC_BITS    = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  typedef struct packed {
    logic   req_type;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
    logic   bad_request;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_BAD,
    CMD_ADV
  } cmd_kind_t;

  // classified command handed from the front end to the stepper
  typedef struct packed {
    cmd_kind_t kind;
    coord_t    start_x;
    coord_t    start_y;
    coord_t    end_x;
    logic      single;
    dec_t      decision;
    dec_t      diag_step;
    dec_t      east_step;
  } cmd_t;

  // queue write side
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  // queue read side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

endpackage

`default_nettype wire

/* rtl/core/btl_front.sv */
// front end: accepts requests, checks the octant and forms the set-up terms
`default_nettype none

module btl_front (
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire btl_pkg::in_item_t in_data,
  input  wire logic             q_full,
  output btl_pkg::q_wr_t        q_wr
);
  import btl_pkg::*;

  logic signed [COORD_BITS:0] run;
  logic signed [COORD_BITS:0] rise;
  logic                       bad;
  dec_t                       run_ext;
  dec_t                       rise_x2;
  cmd_t                       cmd;

  always_comb begin
    run     = $signed({1'b0, in_data.end_x}) - $signed({1'b0, in_data.start_x});
    rise    = $signed({1'b0, in_data.start_y}) - $signed({1'b0, in_data.end_y});
    bad     = run[COORD_BITS] | rise[COORD_BITS] | (rise > run);
    run_ext = $signed({{2{run[COORD_BITS]}}, run});
    rise_x2 = $signed({rise[COORD_BITS], rise, 1'b0});

    cmd.start_x   = in_data.start_x;
    cmd.start_y   = in_data.start_y;
    cmd.end_x     = in_data.end_x;
    cmd.single    = (run == '0);
    cmd.decision  = run_ext - rise_x2;
    cmd.diag_step = $signed({run[COORD_BITS], run, 1'b0}) - rise_x2;
    cmd.east_step = -rise_x2;
    if (in_data.req_type == REQ_ADVANCE) begin
      cmd.kind = CMD_ADV;
    end else if (bad) begin
      cmd.kind = CMD_BAD;
    end else begin
      cmd.kind = CMD_START;
    end
  end

  assign in_stall  = q_full;
  assign q_wr.push = in_valid & ~q_full;
  assign q_wr.cmd  = cmd;

endmodule

`default_nettype wire

/* rtl/core/btl_queue.sv */
// short command queue between the front end and the stepper
`default_nettype none

module btl_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire btl_pkg::q_wr_t q_wr,
  output logic           q_full,
  output btl_pkg::q_rd_t q_rd,
  input  wire logic      q_pop
);
  import btl_pkg::*;

  cmd_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_pop;

  localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

  assign q_full     = (count_r == CNT_FULL);
  assign q_rd.valid = (count_r != '0);
  assign q_rd.cmd   = mem_r[rd_ptr_r];
  assign do_pop     = q_pop & q_rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_wr.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !q_wr.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/btl_back.sv */
// stepper: holds the line state, runs commands and registers the pixel
`default_nettype none

module btl_back (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire btl_pkg::q_rd_t q_rd,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output btl_pkg::out_item_t out_data
);
  import btl_pkg::*;

  coord_t    cur_x_r, cur_x_nxt;
  coord_t    cur_y_r, cur_y_nxt;
  coord_t    stop_x_r, stop_x_nxt;
  dec_t      decision_r, decision_nxt;
  dec_t      diag_step_r, diag_step_nxt;
  dec_t      east_step_r, east_step_nxt;
  logic      busy_r, busy_nxt;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t res;
  logic      res_valid;
  logic      can_take;
  logic      fire;
  cmd_t      cmd;

  assign cmd      = q_rd.cmd;
  assign can_take = ~out_valid_r | ~out_stall;
  assign q_pop    = can_take;
  assign fire     = q_rd.valid & can_take;

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    stop_x_nxt    = stop_x_r;
    decision_nxt  = decision_r;
    diag_step_nxt = diag_step_r;
    east_step_nxt = east_step_r;
    busy_nxt      = busy_r;
    res           = '0;
    res_valid     = 1'b0;
    unique case (cmd.kind)
      CMD_START: begin
        cur_x_nxt     = cmd.start_x;
        cur_y_nxt     = cmd.start_y;
        stop_x_nxt    = cmd.end_x;
        decision_nxt  = cmd.decision;
        diag_step_nxt = cmd.diag_step;
        east_step_nxt = cmd.east_step;
        busy_nxt      = ~cmd.single;
        res.pixel_x    = cmd.start_x;
        res.pixel_y    = cmd.start_y;
        res.last_pixel = cmd.single;
        res_valid      = 1'b1;
      end
      CMD_BAD: begin
        busy_nxt        = 1'b0;
        res.bad_request = 1'b1;
        res_valid       = 1'b1;
      end
      CMD_ADV: begin
        if (busy_r) begin
          if (decision_r < 0) begin
            cur_y_nxt    = cur_y_r - 1'b1;
            decision_nxt = decision_r + diag_step_r;
          end else begin
            decision_nxt = decision_r + east_step_r;
          end
          cur_x_nxt      = cur_x_r + 1'b1;
          busy_nxt       = (cur_x_nxt != stop_x_r);
          res.pixel_x    = cur_x_nxt;
          res.pixel_y    = cur_y_nxt;
          res.last_pixel = (cur_x_nxt == stop_x_r);
          res_valid      = 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      stop_x_r    <= '0;
      decision_r  <= '0;
      diag_step_r <= '0;
      east_step_r <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        cur_x_r     <= cur_x_nxt;
        cur_y_r     <= cur_y_nxt;
        stop_x_r    <= stop_x_nxt;
        decision_r  <= decision_nxt;
        diag_step_r <= diag_step_nxt;
        east_step_r <= east_step_nxt;
        busy_r      <= busy_nxt;
      end
      if (can_take) begin
        out_valid_r <= fire & res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.bad_request |->
      out_data_r.pixel_x == '0 && out_data_r.pixel_y == '0 && !out_data_r.last_pixel)
    else $error("bad request result carries pixel data");

  a_adv_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd.kind == CMD_ADV && busy_r |=> out_valid_r && !out_data_r.bad_request)
    else $error("advance on a busy line gave no pixel");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.last_pixel |=> !busy_r)
    else $error("still busy after the last pixel");

  a_idle_adv: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd.kind == CMD_ADV && !busy_r |=> $stable(cur_x_r) && $stable(cur_y_r))
    else $error("advance while idle moved the position");
`endif

endmodule

`default_nettype wire

/* rtl/core/bresenham_line_octant_stepper.sv */
// top level of the single-octant midpoint line stepper
// a request goes through the front end into the command queue, then the stepper
//   registers its pixel; a stalled pixel output can hold it in the queue
// throughput: one request per cycle via add-and-compare, unless the output stalls
// reset: synchronous active-low rst_n empties the queue and leaves the stepper idle
`default_nettype none

module bresenham_line_octant_stepper (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // request channel
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire btl_pkg::in_item_t in_data,
  // pixel channel
  output logic               out_valid,
  input  wire logic          out_stall,
  output btl_pkg::out_item_t out_data
);
  import btl_pkg::*;

  // front end to queue, queue to stepper
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // classifies each request: start, out-of-octant start, or advance,
  // and precomputes the decision term and both increments for a start
  btl_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  // small queue so a stalled pixel output does not block request intake until it fills
  btl_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // steps east or north-east one pixel per advance, drops advances when idle
  btl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/bresenham_line_octant_stepper_test.sv */
// self-checking testbench for the single-octant midpoint line stepper
`timescale 1ns / 100ps

module bresenham_line_octant_stepper_test;
  import btl_pkg::*;

  // keeps its own copy of the stepper state and the queue of pixels still owed
  class pixel_scoreboard;
    coord_t    line_x;
    coord_t    line_y;
    coord_t    line_stop;
    dec_t      err_term;
    dec_t      diag_inc;
    dec_t      east_inc;
    bit        drawing;
    out_item_t pending_pixels[$];
    int        mismatches;
    int        predicted;

    function new();
      line_x     = '0;
      line_y     = '0;
      line_stop  = '0;
      err_term   = '0;
      diag_inc   = '0;
      east_inc   = '0;
      drawing    = 1'b0;
      mismatches = 0;
      predicted  = 0;
    endfunction

    // work out the pixel, if any, that one accepted request transaction causes
    function void note_request(in_item_t req);
      int        run;
      int        rise;
      out_item_t px;
      px = '0;
      if (req.req_type == REQ_START) begin
        run  = int'(req.end_x) - int'(req.start_x);
        rise = int'(req.start_y) - int'(req.end_y);
        if (run < 0 || rise < 0 || rise > run) begin
          // outside the octant: flag only, stepper goes idle
          drawing        = 1'b0;
          px.bad_request = 1'b1;
        end else begin
          line_x        = req.start_x;
          line_y        = req.start_y;
          line_stop     = req.end_x;
          err_term      = dec_t'(run - 2 * rise);
          diag_inc      = dec_t'(2 * run - 2 * rise);
          east_inc      = dec_t'(-2 * rise);
          drawing       = (run > 0);
          px.pixel_x    = line_x;
          px.pixel_y    = line_y;
          px.last_pixel = (run == 0);
        end
      end else begin
        if (!drawing) return;
        if (err_term < 0) begin
          line_y   = line_y - 1'b1;
          err_term = err_term + diag_inc;
        end else begin
          err_term = err_term + east_inc;
        end
        line_x        = line_x + 1'b1;
        px.pixel_x    = line_x;
        px.pixel_y    = line_y;
        px.last_pixel = (line_x == line_stop);
        if (px.last_pixel) drawing = 1'b0;
      end
      pending_pixels.push_back(px);
      predicted++;
    endfunction

    // compare one accepted pixel transaction with the oldest one owed
    function void check_pixel(out_item_t got);
      out_item_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: x=%0d y=%0d last=%0b bad=%0b",
                   got.pixel_x, got.pixel_y, got.last_pixel, got.bad_request);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_x != want.pixel_x || got.pixel_y != want.pixel_y ||
          got.last_pixel != want.last_pixel || got.bad_request != want.bad_request) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"pixel mismatch: want x=%0d y=%0d last=%0b bad=%0b,",
                    " got x=%0d y=%0d last=%0b bad=%0b"},
                   want.pixel_x, want.pixel_y, want.last_pixel, want.bad_request,
                   got.pixel_x, got.pixel_y, got.last_pixel, got.bad_request);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // quiet: no idling on either side; hold_req: receiver holds off for a long stretch
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  pixel_scoreboard sb = new();

  bresenham_line_octant_stepper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // monitor both channels; a request is noted before a pixel is checked in the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_pixel(out_data);
    end
  end

  // receiver: random stall, quiet stretch, and a long counted hold-off on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 14);
      end
    end
  end

  function automatic in_item_t make_req(logic kind, int sx, int sy, int ex, int ey);
    in_item_t it;
    it.req_type = kind;
    it.start_x  = coord_t'(sx);
    it.start_y  = coord_t'(sy);
    it.end_x    = coord_t'(ex);
    it.end_y    = coord_t'(ey);
    return it;
  endfunction

  // advance with junk in the unused coordinate fields
  function automatic in_item_t make_adv();
    return make_req(REQ_ADVANCE, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // offer one request transaction, with random idle cycles first, and wait for acceptance
  task automatic drive_request(in_item_t it);
    while (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending until every owed pixel has arrived, then let the pipe settle
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // one well-formed line with random placement, sometimes cut short or overrun
  task automatic random_line();
    int pick;
    int run;
    int rise;
    int sx;
    int ey;
    int n;
    pick = $urandom_range(99);
    if (pick < 85)      run = $urandom_range(16);
    else if (pick < 98) run = $urandom_range(200, 17);
    else                run = $urandom_range(600, 201);
    pick = $urandom_range(9);
    if (pick == 0)      rise = 0;
    else if (pick == 1) rise = run;
    else                rise = $urandom_range(run);
    sx = $urandom_range(4095 - run);
    ey = $urandom_range(4095 - rise);
    drive_request(make_req(REQ_START, sx, ey + rise, sx + run, ey));
    n = run;
    pick = $urandom_range(9);
    // cut short: the next start lands while the line is still in progress
    if (pick == 0 && run > 0) n = $urandom_range(run - 1);
    repeat (n) drive_request(make_adv());
    // overrun: advances after the last pixel are ignored
    if (pick == 1) repeat ($urandom_range(3, 1)) drive_request(make_adv());
  endtask

  // a start outside the octant, one of its three ways
  task automatic random_bad_start();
    int sx;
    int sy;
    int ex;
    int ey;
    int run;
    int rise;
    case ($urandom_range(2))
      0: begin
        sx = $urandom_range(4095, 1);
        ex = $urandom_range(sx - 1);
        sy = $urandom_range(4095);
        ey = $urandom_range(4095);
      end
      1: begin
        sy = $urandom_range(4094);
        ey = $urandom_range(4095, sy + 1);
        sx = $urandom_range(4095);
        ex = $urandom_range(4095);
      end
      default: begin
        run  = $urandom_range(4094);
        rise = $urandom_range(4095, run + 1);
        sx   = $urandom_range(4095 - run);
        ey   = $urandom_range(4095 - rise);
        ex   = sx + run;
        sy   = ey + rise;
      end
    endcase
    drive_request(make_req(REQ_START, sx, sy, ex, ey));
  endtask

  task automatic random_phase();
    int r;
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    while (sb.predicted < 1070) begin
      quiet = (sb.predicted > 450 && sb.predicted < 650);
      // receiver holds off while requests keep coming, filling the queue
      if (!held && sb.predicted > 300) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sb.predicted > 750) begin
        paused = 1'b1;
        drain_pixels();
      end
      r = $urandom_range(99);
      if (r < 8)
        drive_request(make_req(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                               $urandom));
      else if (r < 13)
        random_bad_start();
      else
        random_line();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // advance while idle, right after reset
    drive_request(make_req(REQ_ADVANCE, 4095, 4095, 4095, 4095));
    // degenerate lines at both corners, the first followed by an ignored advance
    drive_request(make_req(REQ_START, 0, 0, 0, 0));
    drive_request(make_req(REQ_ADVANCE, 0, 0, 0, 0));
    drive_request(make_req(REQ_START, 4095, 4095, 4095, 4095));
    // the three ways out of the octant
    drive_request(make_req(REQ_START, 10, 10, 5, 10));
    drive_request(make_req(REQ_START, 10, 10, 20, 12));
    drive_request(make_req(REQ_START, 0, 10, 3, 0));
    drive_request(make_req(REQ_START, 4095, 0, 0, 4095));
    // flat full-width line, a few steps, then a start while busy
    drive_request(make_req(REQ_START, 0, 4095, 4095, 4095));
    repeat (3) drive_request(make_adv());
    // steepest full-size line, all diagonal steps
    drive_request(make_req(REQ_START, 0, 4095, 4095, 0));
    repeat (3) drive_request(make_adv());
    // short diagonal ending at the far column
    drive_request(make_req(REQ_START, 4093, 4095, 4095, 4093));
    repeat (3) drive_request(make_adv());
    // bad start while busy leaves the stepper idle
    drive_request(make_req(REQ_START, 0, 10, 8, 6));
    drive_request(make_adv());
    drive_request(make_req(REQ_START, 8, 6, 0, 10));
    drive_request(make_adv());
    drain_pixels();

    random_phase();

    drain_pixels();
    repeat (10) @(posedge clk);
    sb.mismatches += sb.pending_pixels.size();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
